FILE: rtl/v3m_pkg.sv
// ----------------------------------------------------------------------------
// v3m_pkg: shared types, constants and helpers for the vector3 math unit
// Holds operation codes, pipeline latencies, Q-format limits and the
// round / saturate helpers used by the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package v3m_pkg;

  // Default number of fraction bits (Q16.16)
  localparam int FRAC_BITS_DEF = 16;

  // Square root: one stage per result bit plus a rounding stage
  localparam int SQRT_LAT = 33;
  // Quotient bits kept by the divider (magnitude below 2^31, else overflow)
  localparam int QBITS    = 31;
  // Divider: one prep stage plus one stage per quotient bit
  localparam int DIV_LAT  = QBITS + 1;

  // Width of sums and products before rounding
  localparam int WIDE_W   = 67;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_SCALE = 4'd2,
    FN_DIV   = 4'd3,
    FN_DOT   = 4'd4,
    FN_CROSS = 4'd5,
    FN_SQN   = 4'd6,
    FN_NORM  = 4'd7,
    FN_NORMZ = 4'd8,
    FN_NULL  = 4'd9
  } func_t;

  // Saturated value with its clip flag
  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } res_t;

  // Per-item control carried through the product stages
  typedef struct packed {
    func_t func;
    logic  zero;
    logic  szero;
  } ctl_t;

  // Operands carried alongside the square root for the divider
  typedef struct packed {
    func_t              func;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] s;
  } opnd_t;

  // Results resolved in the merge stage
  typedef struct packed {
    func_t              func;
    logic               zero;
    logic               dz;
    logic               sat;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sc;
  } meta_t;

  // Clip a wide signed value to the 32-bit range
  function automatic res_t clip32(input logic signed [WIDE_W-1:0] v);
    res_t r;
    r.val = v[31:0];
    r.sat = 1'b0;
    if (v > Q_MAX) begin
      r.val = Q_MAX;
      r.sat = 1'b1;
    end else if (v < Q_MIN) begin
      r.val = Q_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // Divide by 2^frac rounding half up, then clip
  function automatic res_t rnd_clip(input logic signed [WIDE_W-1:0] v, input int frac);
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] t;
    half = '0;
    half[frac-1] = 1'b1;
    t = (v + half) >>> frac;
    return clip32(t);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/v3m_lane.sv
// ----------------------------------------------------------------------------
// v3m_lane: one component lane
// Two signed 32x32 products and their difference, plus the add/sub result,
// over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module v3m_lane (
  input  wire logic               clk,
  input  wire logic signed [31:0] x0,
  input  wire logic signed [31:0] y0,
  input  wire logic signed [31:0] x1,
  input  wire logic signed [31:0] y1,
  input  wire logic signed [31:0] ai,
  input  wire logic signed [31:0] bi,
  input  wire logic               sub,
  output logic signed [64:0]      diff,
  output logic signed [32:0]      addsub
);

  logic signed [63:0] m0;
  logic signed [63:0] m1;
  logic signed [32:0] as1;

  // Stage 1: products and add/sub
  always_ff @(posedge clk) begin
    m0  <= x0 * y0;
    m1  <= x1 * y1;
    as1 <= sub ? (33'(ai) - 33'(bi)) : (33'(ai) + 33'(bi));
  end

  // Stage 2: product difference
  always_ff @(posedge clk) begin
    diff   <= 65'(m0) - 65'(m1);
    addsub <= as1;
  end

endmodule

`default_nettype wire

FILE: rtl/v3m_sqrt.sv
// ----------------------------------------------------------------------------
// v3m_sqrt: pipelined rounded square root
// One result bit per stage over a 64-bit radicand, then round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module v3m_sqrt (
  input  wire logic        clk,
  input  wire logic [63:0] rad,
  output logic      [32:0] root
);

  logic [34:0] rem_s  [1:32];
  logic [31:0] root_s [1:32];
  logic [63:0] rad_s  [1:32];

  for (genvar j = 0; j < 32; j++) begin : g_stage
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [36:0] cur;
    logic [36:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_s[j];
      assign root_in = root_s[j];
      assign rad_in  = rad_s[j];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {rem_in, rad_in[63-2*j -: 2]};
    assign trial = {3'b000, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (cur >= trial) begin
        rem_s[j+1]  <= 35'(cur - trial);
        root_s[j+1] <= {root_in[30:0], 1'b1};
      end else begin
        rem_s[j+1]  <= cur[34:0];
        root_s[j+1] <= {root_in[30:0], 1'b0};
      end
      rad_s[j+1] <= rad_in;
    end
  end

  // Round: remainder above root means the upper integer is nearer
  always_ff @(posedge clk) begin
    if (rem_s[32] > 35'(root_s[32])) begin
      root <= 33'(root_s[32]) + 33'd1;
    end else begin
      root <= 33'(root_s[32]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/v3m_div.sv
// ----------------------------------------------------------------------------
// v3m_div: pipelined rounding divider for one lane
// Computes a*2^F/d rounded half up, one quotient bit per stage, with an
// up-front overflow test against the 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module v3m_div #(
  parameter int FRAC_BITS = v3m_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [34:0] d,
  output logic signed [31:0]      q,
  output logic                    sat
);

  localparam int NW = 32 + FRAC_BITS + 4;
  localparam int QB = v3m_pkg::QBITS;
  localparam int DW = 36;
  localparam int CW = DW + QB + 1;

  logic signed [NW-1:0] nn;
  logic signed [NW-1:0] n2;
  logic signed [NW-1:0] num;
  logic        [34:0]   dm;
  logic                 dneg;
  logic        [NW-1:0] u;
  logic        [DW-1:0] den;
  logic                 ovf;

  logic [NW-1:0] r_s   [0:QB];
  logic [DW-1:0] den_s [0:QB];
  logic [QB-1:0] q_s   [0:QB];
  logic          neg_s [0:QB];
  logic          ovf_s [0:QB];

  // Prep: fold the divisor sign, form 2n+d over 2d, floor on magnitude
  always_comb begin
    nn   = NW'(a) <<< FRAC_BITS;
    dneg = d[34];
    n2   = dneg ? -nn : nn;
    dm   = dneg ? 35'(-d) : d;
    num  = (n2 <<< 1) + NW'(signed'({1'b0, dm}));
    u    = num[NW-1] ? ~num : num;
    den  = {dm, 1'b0};
    ovf  = CW'(u) >= (CW'(den) << QB);
  end

  always_ff @(posedge clk) begin
    r_s[0]   <= u;
    den_s[0] <= den;
    q_s[0]   <= '0;
    neg_s[0] <= num[NW-1];
    ovf_s[0] <= ovf;
  end

  // Restoring iterations, most significant quotient bit first
  for (genvar j = 0; j < QB; j++) begin : g_iter
    localparam int BIT = QB - 1 - j;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_s[j]) << BIT;
    assign ge    = CW'(r_s[j]) >= trial;

    always_ff @(posedge clk) begin
      r_s[j+1]   <= ge ? NW'(CW'(r_s[j]) - trial) : r_s[j];
      q_s[j+1]   <= q_s[j] | (QB'(ge) << BIT);
      den_s[j+1] <= den_s[j];
      neg_s[j+1] <= neg_s[j];
      ovf_s[j+1] <= ovf_s[j];
    end
  end

  // Negative quotient is the complement of the magnitude floor
  always_comb begin
    sat = ovf_s[QB];
    if (ovf_s[QB]) begin
      q = neg_s[QB] ? v3m_pkg::Q_MIN : v3m_pkg::Q_MAX;
    end else if (neg_s[QB]) begin
      q = ~signed'({1'b0, q_s[QB]});
    end else begin
      q = signed'({1'b0, q_s[QB]});
    end
  end

endmodule

`default_nettype wire

FILE: rtl/v3m_dly.sv
// ----------------------------------------------------------------------------
// v3m_dly: fixed-depth shift line
// Carries item data alongside the square root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module v3m_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] sr [0:DEPTH-1];

  always_ff @(posedge clk) begin
    sr[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      sr[k] <= sr[k-1];
    end
  end

  assign dout = sr[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/vector3_math_unit_top.sv
// ----------------------------------------------------------------------------
// vector3_math_unit_top: Q-format 3-vector math unit
// Add, subtract, scale, divide, dot, cross, squared norm, norm, normalize
// and null test, fully pipelined over three component lanes.
// ----------------------------------------------------------------------------
// The square root (33 stages) and the per-lane divider (32 stages) set the
// delay from the edge that accepts an item to the done strobe.
// Throughput: one item per cycle; busy is high only while rst is held.
// Reset: synchronous rst clears all in-flight items and the done strobe.
// Results leave on a one-cycle done strobe; the receiver cannot stall.
`default_nettype none

module vector3_math_unit_top #(
  parameter int FRAC_BITS = v3m_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         func,
  input  wire logic signed [31:0] ax,
  input  wire logic signed [31:0] ay,
  input  wire logic signed [31:0] az,
  input  wire logic signed [31:0] bx,
  input  wire logic signed [31:0] by,
  input  wire logic signed [31:0] bz,
  input  wire logic signed [31:0] scale_value,
  output logic                    done,
  output logic signed [31:0]      rx,
  output logic signed [31:0]      ry,
  output logic signed [31:0]      rz,
  output logic signed [31:0]      scalar_result,
  output logic                    is_zero,
  output logic                    div_by_zero,
  output logic                    saturated
);

  localparam int VLD_N   = 3 + v3m_pkg::SQRT_LAT + v3m_pkg::DIV_LAT;
  localparam int LATENCY = VLD_N + 2;
  localparam int OPND_W  = $bits(v3m_pkg::opnd_t);
  localparam int META_W  = $bits(v3m_pkg::meta_t);

  // Input registers
  logic                  v0;
  v3m_pkg::func_t        func0;
  logic signed [31:0]    a0 [0:2];
  logic signed [31:0]    b0 [0:2];
  logic signed [31:0]    s0;
  logic [VLD_N-1:0]      vsr;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      vsr <= '0;
    end else begin
      v0  <= start;
      vsr <= {vsr[VLD_N-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    func0 <= v3m_pkg::func_t'(func);
    a0[0] <= ax;
    a0[1] <= ay;
    a0[2] <= az;
    b0[0] <= bx;
    b0[1] <= by;
    b0[2] <= bz;
    s0    <= scale_value;
  end

  // Lanes: operand selection and products
  logic signed [64:0] diff2 [0:2];
  logic signed [32:0] as2   [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;

    always_comb begin
      x0 = '0;
      y0 = '0;
      x1 = '0;
      y1 = '0;
      case (func0)
        v3m_pkg::FN_SCALE: begin
          x0 = a0[i];
          y0 = s0;
        end
        v3m_pkg::FN_DOT: begin
          x0 = a0[i];
          y0 = b0[i];
        end
        v3m_pkg::FN_CROSS: begin
          x0 = a0[(i+1)%3];
          y0 = b0[(i+2)%3];
          x1 = a0[(i+2)%3];
          y1 = b0[(i+1)%3];
        end
        v3m_pkg::FN_SQN, v3m_pkg::FN_NORM, v3m_pkg::FN_NORMZ: begin
          x0 = a0[i];
          y0 = a0[i];
        end
        default: ;
      endcase
    end

    v3m_lane u_lane (
      .clk    (clk),
      .x0     (x0),
      .y0     (y0),
      .x1     (x1),
      .y1     (y1),
      .ai     (a0[i]),
      .bi     (b0[i]),
      .sub    (func0 == v3m_pkg::FN_SUB),
      .diff   (diff2[i]),
      .addsub (as2[i])
    );
  end

  // Control alongside the product stages
  v3m_pkg::ctl_t ctl1, ctl2, ctl3;

  always_ff @(posedge clk) begin
    ctl1.func  <= func0;
    ctl1.zero  <= (a0[0] == '0) && (a0[1] == '0) && (a0[2] == '0);
    ctl1.szero <= (s0 == '0);
    ctl2       <= ctl1;
    ctl3       <= ctl2;
  end

  // Lane total for dot and squared norm
  logic signed [v3m_pkg::WIDE_W-1:0] tot3;
  logic signed [64:0]                diff3 [0:2];
  logic signed [32:0]                as3   [0:2];

  always_ff @(posedge clk) begin
    tot3 <= v3m_pkg::WIDE_W'(diff2[0]) + v3m_pkg::WIDE_W'(diff2[1])
          + v3m_pkg::WIDE_W'(diff2[2]);
    for (int k = 0; k < 3; k++) begin
      diff3[k] <= diff2[k];
      as3[k]   <= as2[k];
    end
  end

  // Merge: round and clip everything that needs no root or quotient
  v3m_pkg::meta_t mg_next, meta4, meta68;
  v3m_pkg::res_t  c0, c1, c2, cs;

  always_comb begin
    mg_next      = '0;
    mg_next.func = ctl3.func;
    mg_next.zero = ctl3.zero;
    c0 = '0;
    c1 = '0;
    c2 = '0;
    cs = '0;
    case (ctl3.func)
      v3m_pkg::FN_ADD, v3m_pkg::FN_SUB: begin
        c0 = v3m_pkg::clip32(v3m_pkg::WIDE_W'(as3[0]));
        c1 = v3m_pkg::clip32(v3m_pkg::WIDE_W'(as3[1]));
        c2 = v3m_pkg::clip32(v3m_pkg::WIDE_W'(as3[2]));
      end
      v3m_pkg::FN_SCALE, v3m_pkg::FN_CROSS: begin
        c0 = v3m_pkg::rnd_clip(v3m_pkg::WIDE_W'(diff3[0]), FRAC_BITS);
        c1 = v3m_pkg::rnd_clip(v3m_pkg::WIDE_W'(diff3[1]), FRAC_BITS);
        c2 = v3m_pkg::rnd_clip(v3m_pkg::WIDE_W'(diff3[2]), FRAC_BITS);
      end
      v3m_pkg::FN_DOT, v3m_pkg::FN_SQN: begin
        cs = v3m_pkg::rnd_clip(tot3, FRAC_BITS);
      end
      v3m_pkg::FN_DIV: begin
        mg_next.dz = ctl3.szero;
      end
      default: ;
    endcase
    mg_next.rx  = c0.val;
    mg_next.ry  = c1.val;
    mg_next.rz  = c2.val;
    mg_next.sc  = cs.val;
    mg_next.sat = c0.sat | c1.sat | c2.sat | cs.sat;
  end

  always_ff @(posedge clk) begin
    meta4 <= mg_next;
  end

  v3m_dly #(.W(META_W), .DEPTH(v3m_pkg::SQRT_LAT + v3m_pkg::DIV_LAT - 1)) u_dly_meta (
    .clk  (clk),
    .din  (meta4),
    .dout (meta68)
  );

  // Square root of the sum of squares
  logic [32:0] nrm36;
  logic [32:0] nrm68;

  v3m_sqrt u_sqrt (
    .clk  (clk),
    .rad  (tot3[63:0]),
    .root (nrm36)
  );

  v3m_dly #(.W(33), .DEPTH(v3m_pkg::DIV_LAT)) u_dly_nrm (
    .clk  (clk),
    .din  (nrm36),
    .dout (nrm68)
  );

  // Operands wait for the root
  v3m_pkg::opnd_t opnd0, opnd36;

  always_comb begin
    opnd0.func = func0;
    opnd0.ax   = a0[0];
    opnd0.ay   = a0[1];
    opnd0.az   = a0[2];
    opnd0.s    = s0;
  end

  v3m_dly #(.W(OPND_W), .DEPTH(3 + v3m_pkg::SQRT_LAT)) u_dly_opnd (
    .clk  (clk),
    .din  (opnd0),
    .dout (opnd36)
  );

  // Dividers: scalar for divide, rounded norm for normalize
  logic signed [34:0] dsel;
  logic signed [31:0] dq   [0:2];
  logic               dsat [0:2];

  assign dsel = (opnd36.func == v3m_pkg::FN_NORMZ) ? signed'({2'b00, nrm36})
                                                   : 35'(opnd36.s);

  v3m_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .a (opnd36.ax), .d (dsel), .q (dq[0]), .sat (dsat[0])
  );
  v3m_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .a (opnd36.ay), .d (dsel), .q (dq[1]), .sat (dsat[1])
  );
  v3m_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk (clk), .a (opnd36.az), .d (dsel), .q (dq[2]), .sat (dsat[2])
  );

  // Final select
  logic signed [31:0] rx_next, ry_next, rz_next, sc_next;
  logic               sat_next;

  always_comb begin
    rx_next  = meta68.rx;
    ry_next  = meta68.ry;
    rz_next  = meta68.rz;
    sc_next  = meta68.sc;
    sat_next = meta68.sat;
    case (meta68.func)
      v3m_pkg::FN_DIV: begin
        if (!meta68.dz) begin
          rx_next  = dq[0];
          ry_next  = dq[1];
          rz_next  = dq[2];
          sat_next = dsat[0] | dsat[1] | dsat[2];
        end
      end
      v3m_pkg::FN_NORM: begin
        if (nrm68 > 33'(v3m_pkg::Q_MAX)) begin
          sc_next  = v3m_pkg::Q_MAX;
          sat_next = 1'b1;
        end else begin
          sc_next  = signed'(nrm68[31:0]);
        end
      end
      v3m_pkg::FN_NORMZ: begin
        if (!meta68.zero) begin
          rx_next  = dq[0];
          ry_next  = dq[1];
          rz_next  = dq[2];
          sat_next = dsat[0] | dsat[1] | dsat[2];
        end
      end
      default: ;
    endcase
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vsr[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    rx            <= rx_next;
    ry            <= ry_next;
    rz            <= rz_next;
    scalar_result <= sc_next;
    is_zero       <= meta68.zero;
    div_by_zero   <= meta68.dz;
    saturated     <= sat_next;
  end

  // Every result strobe traces back to an accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  // Divide by zero reports a clean zero vector
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    (done && div_by_zero) |-> (!saturated && rx == '0 && ry == '0 && rz == '0))
    else $error("divide by zero result not cleared");

  // An item yields a vector or a scalar, never both
  a_vec_or_scalar: assert property (@(posedge clk) disable iff (rst)
    done |-> (scalar_result == '0 || (rx == '0 && ry == '0 && rz == '0)))
    else $error("vector and scalar result both set");

endmodule

`default_nettype wire
